>>> hdl/modbus_rtu_poll_master_macros.svh
// Assertion macros shared by the poll master RTL.
`ifndef MODBUS_RTU_POLL_MASTER_MACROS_SVH
`define MODBUS_RTU_POLL_MASTER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MBRP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define MBRP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/mbrp_pkg.sv
// Shared types, constants and functions for the Modbus RTU poll master.
package mbrp_pkg;

   localparam int ENTRY_DEPTH = 16;
   localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);
   localparam int RX_DEPTH    = 256;
   localparam int RX_AW       = $clog2(RX_DEPTH);
   localparam int RX_CW       = RX_AW + 1;
   localparam int SCAN_IW     = 9;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_RX    = 2'd1;
   localparam logic [1:0] REQ_SEG   = 2'd2;
   localparam logic [1:0] REQ_SPARE = 2'd3;

   localparam logic [1:0] CSR_POLL_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_NUM_ENTRIES   = 2'd1;
   localparam logic [1:0] CSR_EXP_FUNC      = 2'd2;
   localparam logic [1:0] CSR_MIN_LEN       = 2'd3;

   localparam logic [7:0] RST_POLL_INTERVAL = 8'd35;
   localparam logic [4:0] RST_NUM_ENTRIES   = 5'd0;
   localparam logic [7:0] RST_EXP_FUNC      = 8'h03;
   localparam logic [8:0] RST_MIN_LEN       = 9'd25;
   localparam logic [8:0] MIN_LEN_FLOOR     = 9'd5;
   localparam logic [7:0] REQ_FUNC          = 8'h03;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;

   localparam logic RESULT_FRAME = 1'b0;
   localparam logic RESULT_MEAS  = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  rx_byte;
      logic [3:0]  entry_index;
      logic [7:0]  entry_addr;
      logic [7:0]  entry_word_len;
      logic [15:0] entry_reg_offset;
      logic [7:0]  entry_save_place;
      logic        entry_scale_down;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  tx_byte;
      logic [7:0]  store_place;
      logic [31:0] store_value;
      logic        link_ok;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  addr;
      logic [7:0]  reg_count;
      logic [15:0] start_reg;
      logic [7:0]  slot;
      logic        scale_down;
   } seg_type;

   typedef struct packed {
      logic        start;
      logic        scale_down;
      logic [31:0] bits;
   } meas_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } meas_res_type;

   // One byte of CRC-16/MODBUS, bit-reflected.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> hdl/modbus_rtu_poll_master.sv
// A received byte, a table write or a tick that does not fire is handled in the idle state.
// A firing tick scans the buffer and drops the head byte on address/function mismatch,
// when the length runs past the buffer or on a bad CRC, until a reply matches or too few bytes remain.
// A match reads the 4 float bytes, converts them (optionally dividing by ten) and outputs one
// measurement; setup and the 8-byte request frame follow. One item at a time; output may stall.
// Reset (synchronous): counters, link flag and registers to defaults; memories untouched.
`include "modbus_rtu_poll_master_macros.svh"

module modbus_rtu_poll_master import mbrp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [8:0]   csr_wdata
);

   typedef enum logic [16:0] {
      ST_IDLE      = 17'b00000000000000001,
      ST_SEG_LAT   = 17'b00000000000000010,
      ST_SCAN      = 17'b00000000000000100,
      ST_B0        = 17'b00000000000001000,
      ST_B1        = 17'b00000000000010000,
      ST_LEN       = 17'b00000000000100000,
      ST_CRC       = 17'b00000000001000000,
      ST_CHK_LO    = 17'b00000000010000000,
      ST_CHK_HI    = 17'b00000000100000000,
      ST_FLT       = 17'b00000001000000000,
      ST_CONV      = 17'b00000010000000000,
      ST_MEAS_OUT  = 17'b00000100000000000,
      ST_DROP      = 17'b00001000000000000,
      ST_NEXT      = 17'b00010000000000000,
      ST_FRAME_LAT = 17'b00100000000000000,
      ST_FRAME_CRC = 17'b01000000000000000,
      ST_FRAME_OUT = 17'b10000000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0] poll_interval_ff, poll_interval_in;
   logic [4:0] num_entries_ff, num_entries_in;
   logic [7:0] exp_func_ff, exp_func_in;
   logic [8:0] min_len_ff, min_len_in;

   logic [RX_AW-1:0]    rx_head_ff, rx_head_in;
   logic [RX_CW-1:0]    rx_count_ff, rx_count_in;
   logic [7:0]          tick_ff, tick_in;
   logic [ENTRY_AW-1:0] pos_ff, pos_in;
   logic                link_ff, link_in;

   seg_type            seg_ff, seg_in;
   logic [7:0]         b0_ff, b0_in;
   logic [7:0]         n_ff, n_in;
   logic [15:0]        crc_ff, crc_in;
   logic [SCAN_IW-1:0] idx_ff, idx_in;
   logic [7:0]         lo_ff, lo_in;
   logic [31:0]        flt_ff, flt_in;
   logic [1:0]         fk_ff, fk_in;
   logic [2:0]         j_ff, j_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   // memory ports
   logic                rx_we;
   logic [RX_AW-1:0]    rx_waddr;
   logic [RX_AW-1:0]    rx_raddr;
   logic [7:0]          rx_rdata;
   logic [SCAN_IW-1:0]  rd_idx;
   logic                seg_we;
   logic [ENTRY_AW-1:0] seg_waddr;
   seg_type             seg_wdata;
   logic [ENTRY_AW-1:0] seg_raddr;
   seg_type             seg_rdata;

   meas_cmd_type meas_cmd;
   meas_res_type meas_res;

   logic                accept;
   logic                out_free;
   logic [ENTRY_AW:0]   used;
   logic [ENTRY_AW:0]   pos_inc;
   logic [ENTRY_AW-1:0] pos_next;
   logic [8:0]          min_len_eff;
   logic [7:0]          frame_byte;
   logic [9:0]          crc_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign used        = (int'(num_entries_ff) > ENTRY_DEPTH) ? (ENTRY_AW+1)'(ENTRY_DEPTH)
                                                           : (ENTRY_AW+1)'(num_entries_ff);
   assign pos_inc     = {1'b0, pos_ff} + {{ENTRY_AW{1'b0}}, 1'b1};
   assign pos_next    = (pos_inc >= used) ? '0 : pos_inc[ENTRY_AW-1:0];
   assign min_len_eff = (min_len_ff < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len_ff;
   assign crc_last    = {2'b00, n_ff} + 10'd2;

   always_comb begin
      unique case (j_ff)
         3'd0:    frame_byte = seg_ff.addr;
         3'd1:    frame_byte = REQ_FUNC;
         3'd2:    frame_byte = seg_ff.start_reg[15:8];
         3'd3:    frame_byte = seg_ff.start_reg[7:0];
         3'd4:    frame_byte = 8'h00;
         3'd5:    frame_byte = seg_ff.reg_count;
         3'd6:    frame_byte = crc_ff[7:0];
         3'd7:    frame_byte = crc_ff[15:8];
         default: frame_byte = 8'h00;
      endcase
   end

   always_comb begin
      poll_interval_in = poll_interval_ff;
      num_entries_in   = num_entries_ff;
      exp_func_in      = exp_func_ff;
      min_len_in       = min_len_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POLL_INTERVAL: poll_interval_in = csr_wdata[7:0];
            CSR_NUM_ENTRIES:   num_entries_in   = csr_wdata[4:0];
            CSR_EXP_FUNC:      exp_func_in      = csr_wdata[7:0];
            CSR_MIN_LEN:       min_len_in       = csr_wdata;
            default:           ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rx_head_in   = rx_head_ff;
      rx_count_in  = rx_count_ff;
      tick_in      = tick_ff;
      pos_in       = pos_ff;
      link_in      = link_ff;
      seg_in       = seg_ff;
      b0_in        = b0_ff;
      n_in         = n_ff;
      crc_in       = crc_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      flt_in       = flt_ff;
      fk_in        = fk_ff;
      j_in         = j_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_idx       = '0;
      seg_raddr    = pos_ff;
      rx_we        = 1'b0;
      seg_we       = 1'b0;
      meas_cmd     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_data.req_type == REQ_RX) begin
                  if (int'(rx_count_ff) < RX_DEPTH) begin
                     rx_we       = 1'b1;
                     rx_count_in = rx_count_ff + RX_CW'(1);
                  end
               end else if (req_data.req_type == REQ_SEG) begin
                  seg_we = (int'(req_data.entry_index) < ENTRY_DEPTH);
               end else if (req_data.req_type == REQ_TICK) begin
                  if (used != '0) begin
                     if (tick_ff < poll_interval_ff) begin
                        tick_in = tick_ff + 8'd1;
                     end else begin
                        tick_in  = 8'd0;
                        state_in = ST_SEG_LAT;
                     end
                  end
               end else begin
               end
            end
         end
         ST_SEG_LAT: begin
            seg_in   = seg_rdata;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (32'(rx_count_ff) >= 32'(min_len_eff)) begin
               rd_idx   = SCAN_IW'(0);
               state_in = ST_B0;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_B0: begin
            b0_in    = rx_rdata;
            rd_idx   = SCAN_IW'(1);
            state_in = ST_B1;
         end
         ST_B1: begin
            if ((b0_ff == seg_ff.addr) && (rx_rdata == exp_func_ff)) begin
               rd_idx   = SCAN_IW'(2);
               state_in = ST_LEN;
            end else begin
               state_in = ST_DROP;
            end
         end
         ST_LEN: begin
            n_in = rx_rdata;
            if (32'(rx_rdata) + 32'd4 < 32'(rx_count_ff)) begin
               crc_in   = CRC_INIT;
               idx_in   = '0;
               rd_idx   = SCAN_IW'(0);
               state_in = ST_CRC;
            end else begin
               state_in = ST_DROP;
            end
         end
         ST_CRC: begin
            crc_in = crc_byte(crc_ff, rx_rdata);
            if (10'(idx_ff) == crc_last) begin
               rd_idx   = SCAN_IW'({2'b00, n_ff} + 10'd3);
               state_in = ST_CHK_LO;
            end else begin
               idx_in = idx_ff + SCAN_IW'(1);
               rd_idx = idx_ff + SCAN_IW'(1);
            end
         end
         ST_CHK_LO: begin
            lo_in    = rx_rdata;
            rd_idx   = SCAN_IW'({2'b00, n_ff} + 10'd4);
            state_in = ST_CHK_HI;
         end
         ST_CHK_HI: begin
            if ({rx_rdata, lo_ff} == crc_ff) begin
               link_in     = 1'b1;
               rx_count_in = '0;
               fk_in       = 2'd0;
               rd_idx      = SCAN_IW'(7);
               state_in    = ST_FLT;
            end else begin
               state_in = ST_DROP;
            end
         end
         ST_FLT: begin
            // bytes 7..10 arrive in order; float is bytes 9,10,7,8
            flt_in = {flt_ff[23:0], rx_rdata};
            fk_in  = fk_ff + 2'd1;
            rd_idx = SCAN_IW'(8) + SCAN_IW'(fk_ff);
            if (fk_ff == 2'd3) begin
               meas_cmd.start      = 1'b1;
               meas_cmd.scale_down = seg_ff.scale_down;
               meas_cmd.bits       = {flt_ff[7:0], rx_rdata, flt_ff[23:16], flt_ff[15:8]};
               state_in            = ST_CONV;
            end
         end
         ST_CONV: begin
            if (meas_res.done) begin
               flt_in   = meas_res.value;
               state_in = ST_MEAS_OUT;
            end
         end
         ST_MEAS_OUT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_kind  = RESULT_MEAS;
               rsp_in.tx_byte      = 8'h00;
               rsp_in.store_place  = seg_ff.slot;
               rsp_in.store_value  = flt_ff;
               rsp_in.link_ok      = link_ff;
               rsp_in.last         = 1'b0;
               state_in            = ST_NEXT;
            end
         end
         ST_DROP: begin
            rx_head_in  = rx_head_ff + RX_AW'(1);
            rx_count_in = rx_count_ff - RX_CW'(1);
            link_in     = 1'b0;
            state_in    = ST_SCAN;
         end
         ST_NEXT: begin
            pos_in    = pos_next;
            seg_raddr = pos_next;
            state_in  = ST_FRAME_LAT;
         end
         ST_FRAME_LAT: begin
            seg_in   = seg_rdata;
            crc_in   = CRC_INIT;
            j_in     = 3'd0;
            state_in = ST_FRAME_CRC;
         end
         ST_FRAME_CRC: begin
            crc_in = crc_byte(crc_ff, frame_byte);
            if (j_ff == 3'd5) begin
               j_in     = 3'd0;
               state_in = ST_FRAME_OUT;
            end else begin
               j_in = j_ff + 3'd1;
            end
         end
         ST_FRAME_OUT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_kind  = RESULT_FRAME;
               rsp_in.tx_byte      = frame_byte;
               rsp_in.store_place  = 8'h00;
               rsp_in.store_value  = 32'd0;
               rsp_in.link_ok      = link_ff;
               rsp_in.last         = (j_ff == 3'd7);
               j_in                = j_ff + 3'd1;
               if (j_ff == 3'd7) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rx_waddr  = rx_head_ff + RX_AW'(rx_count_ff);
   assign rx_raddr  = rx_head_ff + RX_AW'(rd_idx);
   assign seg_waddr = ENTRY_AW'(req_data.entry_index);
   assign seg_wdata = '{addr:       req_data.entry_addr,
                        reg_count:  req_data.entry_word_len,
                        start_reg:  req_data.entry_reg_offset,
                        slot:       req_data.entry_save_place,
                        scale_down: req_data.entry_scale_down};

   mbrp_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock (clock),
      .we    (rx_we),
      .waddr (rx_waddr),
      .wdata (req_data.rx_byte),
      .raddr (rx_raddr),
      .rdata (rx_rdata)
   );

   mbrp_ram #(.WIDTH($bits(seg_type)), .DEPTH(ENTRY_DEPTH)) u_seg_ram (
      .clock (clock),
      .we    (seg_we),
      .waddr (seg_waddr),
      .wdata (seg_wdata),
      .raddr (seg_raddr),
      .rdata (seg_rdata)
   );

   mbrp_meas u_meas (
      .clock (clock),
      .reset (reset),
      .cmd   (meas_cmd),
      .res   (meas_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         poll_interval_ff <= RST_POLL_INTERVAL;
         num_entries_ff   <= RST_NUM_ENTRIES;
         exp_func_ff      <= RST_EXP_FUNC;
         min_len_ff       <= RST_MIN_LEN;
         rx_head_ff       <= '0;
         rx_count_ff      <= '0;
         tick_ff          <= 8'd0;
         pos_ff           <= '0;
         link_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         poll_interval_ff <= poll_interval_in;
         num_entries_ff   <= num_entries_in;
         exp_func_ff      <= exp_func_in;
         min_len_ff       <= min_len_in;
         rx_head_ff       <= rx_head_in;
         rx_count_ff      <= rx_count_in;
         tick_ff          <= tick_in;
         pos_ff           <= pos_in;
         link_ff          <= link_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      seg_ff <= seg_in;
      b0_ff  <= b0_in;
      n_ff   <= n_in;
      crc_ff <= crc_in;
      idx_ff <= idx_in;
      lo_ff  <= lo_in;
      flt_ff <= flt_in;
      fk_ff  <= fk_in;
      j_ff   <= j_in;
      rsp_ff <= rsp_in;
   end

   `MBRP_ASSERT_NOW(a_rx_count_bound, 1'b1, int'(rx_count_ff) <= RX_DEPTH)
   `MBRP_ASSERT_NOW(a_last_is_frame, rsp_valid_ff && rsp_ff.last,
                    rsp_ff.result_kind == RESULT_FRAME)
   `MBRP_ASSERT_NOW(a_meas_has_link, rsp_valid_ff && (rsp_ff.result_kind == RESULT_MEAS),
                    rsp_ff.link_ok)
   `MBRP_ASSERT_NEXT(a_match_clears_buf, (state_ff == ST_CHK_HI) && (state_in == ST_FLT),
                     (rx_count_ff == '0) && link_ff)

endmodule

>>> hdl/mbrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> hdl/mbrp_meas.sv
// Measurement unit: float times ten, truncated to unsigned, optional divide by ten.
module mbrp_meas import mbrp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  meas_cmd_type cmd,
   output meas_res_type res
);

   typedef enum logic [4:0] {
      M_IDLE = 5'b00001,
      M_MUL  = 5'b00010,
      M_RND  = 5'b00100,
      M_DIV  = 5'b01000,
      M_DONE = 5'b10000
   } meas_state_type;

   // x / 10 == (x * ceil(2^35 / 10)) >> 35 for every 32-bit x
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;

   meas_state_type state_ff, state_in;
   logic [31:0] bits_ff, bits_in;
   logic        scale_ff, scale_in;
   logic [27:0] prod_ff, prod_in;
   logic [7:0]  exp_ff, exp_in;
   logic        zero_ff, zero_in;
   logic        sat_ff, sat_in;
   logic [31:0] val_ff, val_in;

   logic [23:0]       mant;
   logic [23:0]       keep;
   logic              rbit, sticky, rnd;
   logic [24:0]       mr;
   logic signed [9:0] eadj;
   logic [9:0]        eneg;
   logic [63:0]       quot_wide;

   always_comb begin
      state_in = state_ff;
      bits_in  = bits_ff;
      scale_in = scale_ff;
      prod_in  = prod_ff;
      exp_in   = exp_ff;
      zero_in  = zero_ff;
      sat_in   = sat_ff;
      val_in   = val_ff;

      mant = {1'b1, bits_ff[22:0]};
      if (prod_ff[27]) begin
         keep   = prod_ff[27:4];
         rbit   = prod_ff[3];
         sticky = |prod_ff[2:0];
      end else begin
         keep   = prod_ff[26:3];
         rbit   = prod_ff[2];
         sticky = |prod_ff[1:0];
      end
      rnd  = rbit & (sticky | keep[0]);
      mr   = {1'b0, keep} + {24'd0, rnd};
      eadj = $signed({2'b00, exp_ff}) - 10'sd150 + (prod_ff[27] ? 10'sd4 : 10'sd3);
      eneg = 10'(-eadj);
      quot_wide = {32'd0, val_ff} * {32'd0, DIV10_RECIP};

      unique case (state_ff)
         M_IDLE: begin
            if (cmd.start) begin
               bits_in  = cmd.bits;
               scale_in = cmd.scale_down;
               state_in = M_MUL;
            end
         end
         M_MUL: begin
            // sign, zero/denormal, NaN -> 0; +inf -> saturate
            zero_in  = bits_ff[31] || (bits_ff[30:23] == 8'd0) ||
                       ((bits_ff[30:23] == 8'hFF) && (bits_ff[22:0] != 23'd0));
            sat_in   = !bits_ff[31] && (bits_ff[30:23] == 8'hFF) && (bits_ff[22:0] == 23'd0);
            prod_in  = {1'b0, mant, 3'b000} + {3'b000, mant, 1'b0};
            exp_in   = bits_ff[30:23];
            state_in = M_RND;
         end
         M_RND: begin
            if (zero_ff) begin
               val_in = 32'd0;
            end else if (sat_ff || (eadj > 10'sd8) || ((eadj == 10'sd8) && mr[24])) begin
               val_in = 32'hFFFF_FFFF;
            end else if (eadj >= 10'sd0) begin
               val_in = 32'(mr) << eadj[3:0];
            end else if (eneg >= 10'd25) begin
               val_in = 32'd0;
            end else begin
               val_in = 32'(mr >> eneg[4:0]);
            end
            state_in = scale_ff ? M_DIV : M_DONE;
         end
         M_DIV: begin
            // divide by ten as a reciprocal multiply
            val_in   = 32'(quot_wide >> 35);
            state_in = M_DONE;
         end
         M_DONE: begin
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bits_ff  <= bits_in;
      scale_ff <= scale_in;
      prod_ff  <= prod_in;
      exp_ff   <= exp_in;
      zero_ff  <= zero_in;
      sat_ff   <= sat_in;
      val_ff   <= val_in;
   end

   assign res.done  = (state_ff == M_DONE);
   assign res.value = val_ff;

endmodule

>>> tb/modbus_rtu_poll_master_test.sv
// Self-checking testbench for the Modbus RTU poll master: random poll traffic against a predictor.
`timescale 1ns / 100ps

module modbus_rtu_poll_master_test;
   import mbrp_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [8:0]   csr_wdata;

   modbus_rtu_poll_master dut (.*);

   // predictor state
   seg_type      seg_tbl [ENTRY_DEPTH];
   logic [7:0]   rx_q [$];
   logic [7:0]   tick_cnt;
   logic [3:0]   poll_pos;
   logic         link;
   logic [7:0]   cfg_interval;
   logic [4:0]   cfg_entries;
   logic [7:0]   cfg_func;
   logic [8:0]   cfg_minlen;

   req_item_type pending_items [$];
   rsp_item_type expected_rsp [$];
   int           errors;
   int           item_total;
   bit           calm;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] crc16(input logic [7:0] d [$], input int n);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int i = 0; i < n; i++) begin
         c = c ^ {8'h00, d[i]};
         for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
         end
      end
      return c;
   endfunction

   // Single-precision f*10 rounded to nearest even, then truncated to unsigned.
   function automatic logic [31:0] times_ten(input logic [31:0] f);
      logic [7:0]  e;
      logic [63:0] p, q, rem, half;
      int          s, sh, msb;
      e = f[30:23];
      if (e == 8'hFF) return (f[22:0] != 0 || f[31]) ? 32'd0 : 32'hFFFFFFFF;
      if (f[31]) return 32'd0;
      p = (e == 0) ? {41'd0, f[22:0]} : {40'd0, 1'b1, f[22:0]};
      p = p * 10;
      if (p == 0) return 32'd0;
      msb = 0;
      for (int i = 0; i < 64; i++) if (p[i]) msb = i;
      s = msb - 23;
      q = p;
      if (s > 0) begin
         q = p >> s;
         rem = p & ((64'd1 << s) - 1);
         half = 64'd1 << (s - 1);
         if (rem > half || (rem == half && q[0])) q = q + 1;
      end else begin
         s = 0;
      end
      sh = s + ((e == 0) ? 1 : int'(e)) - 150;
      if (sh >= 0) begin
         if (sh >= 32) return 32'hFFFFFFFF;
         q = q << sh;
         return (q >= 64'h1_0000_0000) ? 32'hFFFFFFFF : q[31:0];
      end
      if (-sh >= 64) return 32'd0;
      q = q >> (-sh);
      return q[31:0];
   endfunction

   task automatic predict_poll();
      int           used, minlen, n;
      int unsigned  pos;
      bit           ok, hit;
      logic [31:0]  val;
      logic [7:0]   place;
      logic [7:0]   fr [$];
      logic [15:0]  c;
      rsp_item_type r;
      used = (cfg_entries > ENTRY_DEPTH) ? ENTRY_DEPTH : int'(cfg_entries);
      if (used == 0) return;
      if (int'(tick_cnt) + 1 <= int'(cfg_interval)) begin
         tick_cnt = tick_cnt + 1;
         return;
      end
      tick_cnt = 0;
      pos = poll_pos;
      minlen = (cfg_minlen < 5) ? 5 : int'(cfg_minlen);
      hit = 0;
      val = 0;
      place = 0;
      while (rx_q.size() >= minlen) begin
         ok = rx_q[0] == seg_tbl[pos].addr && rx_q[1] == cfg_func;
         if (ok) begin
            n = rx_q[2];
            if (n + 4 < rx_q.size()) ok = {rx_q[n + 4], rx_q[n + 3]} == crc16(rx_q, n + 3);
            else ok = 0;
         end
         if (ok) begin
            val = times_ten({rx_q[9], rx_q[10], rx_q[7], rx_q[8]});
            if (seg_tbl[pos].scale_down) val = val / 10;
            place = seg_tbl[pos].slot;
            hit = 1;
            rx_q.delete();
            link = 1;
            break;
         end
         void'(rx_q.pop_front());
         link = 0;
      end
      if (hit) begin
         r = '{result_kind: RESULT_MEAS, tx_byte: 8'd0, store_place: place,
               store_value: val, link_ok: link, last: 1'b0};
         expected_rsp.push_back(r);
      end
      pos = pos + 1;
      if (pos >= used) pos = 0;
      poll_pos = pos;
      fr = '{seg_tbl[pos].addr, REQ_FUNC, seg_tbl[pos].start_reg[15:8],
             seg_tbl[pos].start_reg[7:0], 8'd0, seg_tbl[pos].reg_count};
      c = crc16(fr, 6);
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      for (int i = 0; i < 8; i++) begin
         r = '{result_kind: RESULT_FRAME, tx_byte: fr[i], store_place: 8'd0,
               store_value: 32'd0, link_ok: link, last: (i == 7)};
         expected_rsp.push_back(r);
      end
   endtask

   task automatic predict_item(input req_item_type it);
      case (it.req_type)
         REQ_RX: if (rx_q.size() < RX_DEPTH) rx_q.push_back(it.rx_byte);
         REQ_SEG: seg_tbl[it.entry_index] = '{addr: it.entry_addr, reg_count: it.entry_word_len,
                                             start_reg: it.entry_reg_offset,
                                             slot: it.entry_save_place,
                                             scale_down: it.entry_scale_down};
         REQ_TICK: predict_poll();
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_item(req_data);
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      rsp_item_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= 31;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_data);
               errors++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("result_kind", e.result_kind, rsp_data.result_kind);
               check_field("tx_byte", e.tx_byte, rsp_data.tx_byte);
               check_field("store_place", e.store_place, rsp_data.store_place);
               check_field("store_value", e.store_value, rsp_data.store_value);
               check_field("link_ok", e.link_ok, rsp_data.link_ok);
               check_field("last", e.last, rsp_data.last);
            end
         end
      end
   end

   task automatic push_item(input req_item_type it);
      pending_items.push_back(it);
      item_total++;
   endtask

   task automatic send(input logic [1:0] kind, input logic [7:0] b);
      req_item_type it;
      it = req_item_type'($bits(req_item_type)'({$urandom, $urandom}));
      it.req_type = kind;
      it.rx_byte = b;
      push_item(it);
   endtask

   task automatic send_seg(input logic [3:0] idx);
      req_item_type it;
      it = req_item_type'($bits(req_item_type)'({$urandom, $urandom}));
      it.req_type = REQ_SEG;
      it.entry_index = idx;
      push_item(it);
   endtask

   task automatic wait_accepted();
      while (pending_items.size() > 0 || req_valid) @(negedge clock);
   endtask

   task automatic settle();
      wait_accepted();
      while (expected_rsp.size() > 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [8:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_POLL_INTERVAL: cfg_interval = v[7:0];
         CSR_NUM_ENTRIES:   cfg_entries = v[4:0];
         CSR_EXP_FUNC:      cfg_func = v[7:0];
         default:           cfg_minlen = v;
      endcase
   endtask

   task automatic configure(input logic [7:0] ivl, input logic [4:0] ent,
                            input logic [7:0] fn, input logic [8:0] ml);
      settle();
      csr_write(CSR_POLL_INTERVAL, {1'b0, ivl});
      csr_write(CSR_NUM_ENTRIES, {4'd0, ent});
      csr_write(CSR_EXP_FUNC, {1'b0, fn});
      csr_write(CSR_MIN_LEN, ml);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] pick_float();
      case ($urandom_range(11))
         0: return 32'd0;
         1: return 32'h8000_0000 | $urandom;
         2: return 32'h7FC0_0001;
         3: return 32'h7F80_0000;
         4: return 32'h5F00_0000 | $urandom_range(32'h7FFFFF);
         5: return {9'd0, 23'($urandom)};
         default: return {1'b0, 8'($urandom_range(118, 158)), 23'($urandom)};
      endcase
   endfunction

   // kind: 0 good reply, 1 bad crc, 2 wrong address
   task automatic send_reply(input int kind);
      logic [7:0]  fr [$];
      logic [31:0] fv;
      logic [15:0] c;
      int          n;
      n = 2 * $urandom_range(4, 8);
      fv = pick_float();
      fr.push_back(kind == 2 ? seg_tbl[poll_pos].addr ^ 8'($urandom_range(1, 255))
                             : seg_tbl[poll_pos].addr);
      fr.push_back(cfg_func);
      fr.push_back(8'(n));
      for (int i = 0; i < n; i++) fr.push_back(8'($urandom));
      fr[7] = fv[15:8];
      fr[8] = fv[7:0];
      fr[9] = fv[31:24];
      fr[10] = fv[23:16];
      c = crc16(fr, n + 3);
      if (kind == 1) c = c ^ 16'(1 << $urandom_range(15));
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
      foreach (fr[i]) send(REQ_RX, fr[i]);
   endtask

   // one poll: optional noise, a reply for the current entry or random bytes, ticks up to firing
   task automatic poll_round();
      int k;
      wait_accepted();
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 3)) send(REQ_RX, 8'($urandom));
      k = $urandom_range(9);
      if (k < 7) send_reply(0);
      else if (k == 7) send_reply(1);
      else if (k == 8) send_reply(2);
      else repeat ($urandom_range(1, 8)) send(REQ_RX, 8'($urandom));
      if ($urandom_range(7) == 0) send(REQ_SPARE, 8'($urandom));
      if ($urandom_range(9) == 0) send_seg(4'($urandom));
      repeat (int'(cfg_interval) + 1 - int'(tick_cnt)) send(REQ_TICK, 8'($urandom));
   endtask

   task automatic random_phase(input int count);
      int stop;
      stop = item_total + count;
      while (item_total < stop) poll_round();
   endtask

   initial begin
      req_item_type it;
      reset     <= 1'b1;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_POLL_INTERVAL;
      csr_wdata <= '0;
      errors = 0;
      item_total = 0;
      calm = 0;
      rx_q.delete();
      tick_cnt = 0;
      poll_pos = 0;
      link = 0;
      cfg_interval = RST_POLL_INTERVAL;
      cfg_entries = RST_NUM_ENTRIES;
      cfg_func = RST_EXP_FUNC;
      cfg_minlen = RST_MIN_LEN;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: fill the table with extreme entries first, then odd items
      configure(8'd0, 5'd0, 8'h03, 9'd0);
      it = '0;
      it.req_type = REQ_SEG;
      push_item(it);
      it = '1;
      it.req_type = REQ_SEG;
      push_item(it);
      for (int i = 1; i < ENTRY_DEPTH - 1; i++) send_seg(4'(i));
      send(REQ_TICK, 8'h00);   // ignored, polling disabled
      send(REQ_SPARE, 8'hFF);
      send(REQ_RX, 8'h00);
      send(REQ_RX, 8'hFF);
      configure(8'd0, 5'd16, 8'h03, 9'd5);
      send(REQ_TICK, 8'h00);
      random_phase(20);

      // no idling for a while
      calm = 1;
      configure(8'd2, 5'd16, 8'h03, 9'd11);
      random_phase(100);
      calm = 0;

      // too many entries, big threshold: the scan never runs
      configure(8'd0, 5'd31, 8'hFF, 9'd256);
      random_phase(20);

      // shrink the table under the current position, longer interval
      configure(8'd20, 5'd3, 8'h00, 9'd12);
      poll_round();
      random_phase(10);

      configure(8'd1, 5'd5, 8'($urandom), 9'($urandom_range(5, 20)));
      random_phase(60);
      configure(8'($urandom_range(0, 4)), 5'd1, 8'h03, 9'd0);
      random_phase(30);

      configure(8'd0, 5'd0, 8'h03, 9'd25);
      repeat (3) send(REQ_TICK, 8'h00);
      settle();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/mbrp_pkg.sv
hdl/mbrp_ram.sv
hdl/mbrp_meas.sv
hdl/modbus_rtu_poll_master.sv
tb/modbus_rtu_poll_master_test.sv
